// ===== src/wsrx_pkg.sv =====
// Package for the WebSocket receive deframer: parse phases, result codes,
// header constants and the result record. No dependencies.
package wsrx_pkg;

    localparam int BUFFER_LEN_BITS_DEF = 16;
    localparam int BUF_LEN_W           = 16;   // width of the buffer_length field

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DONE    = 3'd5
    } t_phase;

    // result_kind codes
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_EMPTY  = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // header constants
    localparam logic [3:0] OPC_CLOSE  = 4'h8;
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] payload_byte;
        logic       last_of_frame;
        logic       close_request;
        logic [3:0] frame_opcode;
        logic       final_fragment;
    } t_result;

endpackage

// ===== src/wsrx_if.sv =====
// Stream interfaces of the WebSocket receive deframer: raw byte channel and
// result channel. Depends on wsrx_pkg.
interface wsrx_in_if
    import wsrx_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [7:0]           in_byte;
    logic                 frame_start;
    logic [BUF_LEN_W-1:0] buffer_length;

    modport source (output valid, output in_byte, output frame_start,
                    output buffer_length, input ready);
    modport sink   (input valid, input in_byte, input frame_start,
                    input buffer_length, output ready);
endinterface

interface wsrx_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic       close_request;
    logic [3:0] frame_opcode;
    logic       final_fragment;

    modport source (output valid, output result_kind, output payload_byte,
                    output last_of_frame, output close_request,
                    output frame_opcode, output final_fragment, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input last_of_frame, input close_request,
                    input frame_opcode, input final_fragment, output ready);
endinterface

// ===== src/wsrx_skid.sv =====
// Result register with a skid entry behind it; upstream ready is registered.
// Depends on wsrx_pkg (t_result).
module wsrx_skid
    import wsrx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_pop_ready
);

    logic    r_out_v;
    logic    r_skid_v;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop     = r_out_v && i_pop_ready;
    assign o_ready = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || pop) begin
            // output slot frees: refill from skid first, else from new transfer
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= i_push;
            end
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || pop) begin
            r_out <= r_skid_v ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

// ===== src/websocket_rx_deframe_unmask.sv =====
// Top level of the WebSocket receive deframer and unmasker (RFC 6455 layout).
// Depends on wsrx_pkg, wsrx_if.sv (wsrx_in_if, wsrx_out_if) and wsrx_skid.
//
//  channel | dir | payload                                          | transfer when
//  --------+-----+--------------------------------------------------+------------------
//  i_in    | in  | in_byte, frame_start, buffer_length              | valid && ready
//  o_out   | out | result_kind, payload_byte, last_of_frame,        | valid && ready
//          |     | close_request, frame_opcode, final_fragment      |
//
// One byte per cycle while i_in.ready is high. Each accepted byte updates the parser
// state as it arrives; its result, if any, is registered before it appears on o_out.
// Reset (synchronous, i_rst_n low) returns the parser to idle and empties the output.
// A stall on o_out is absorbed by the skid entry; i_in.ready drops only while
// both the result register and the skid entry hold results.
module websocket_rx_deframe_unmask
    import wsrx_pkg::*;
#(
    parameter int BUFFER_LEN_BITS = BUFFER_LEN_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wsrx_in_if.sink   i_in,
    wsrx_out_if.source o_out
);

    // Buffer limit keeps the low min(BUFFER_LEN_BITS, 16) bits of the 16-bit field.
    localparam int LIM_W = (BUFFER_LEN_BITS < BUF_LEN_W) ? BUFFER_LEN_BITS : BUF_LEN_W;

    // Parser state
    t_phase           r_phase,   n_phase;
    logic [2:0]       r_idx,     n_idx;      // ext length bytes left - 1, or key byte index
    logic [3:0]       r_opcode,  n_opcode;
    logic             r_fin,     n_fin;
    logic [LIM_W-1:0] r_len_lo,  n_len_lo;   // payload length, low bits
    logic             r_len_hi,  n_len_hi;   // some length bit above the low part is set
    logic [31:0]      r_key,     n_key;
    logic [LIM_W-1:0] r_cnt,     n_cnt;      // payload bytes already delivered
    logic [LIM_W-1:0] r_limit,   n_limit;

    logic             accept;
    logic             push;
    t_result          res;
    logic             skid_ready;
    logic             out_valid;
    t_result          out_data;

    logic [7:0]       b;
    logic [6:0]       len7;
    logic [LIM_W+7:0] len_shift;
    logic [LIM_W-1:0] cnt_inc;
    logic [7:0]       key_byte;
    logic             last;

    assign accept = i_in.valid && skid_ready;
    assign b      = i_in.in_byte;
    assign len7   = b[6:0];
    assign len_shift = {r_len_lo, b};
    assign cnt_inc   = r_cnt + LIM_W'(1);
    assign last      = (cnt_inc >= r_len_lo);

    // Key bytes go most significant first, cycling every four payload bytes.
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_opcode = r_opcode;
        n_fin    = r_fin;
        n_len_lo = r_len_lo;
        n_len_hi = r_len_hi;
        n_key    = r_key;
        n_cnt    = r_cnt;
        n_limit  = r_limit;
        push     = 1'b0;

        res.result_kind    = KIND_DATA;
        res.payload_byte   = 8'd0;
        res.last_of_frame  = 1'b0;
        res.close_request  = 1'b0;
        res.frame_opcode   = r_opcode;
        res.final_fragment = r_fin;

        if (accept) begin
            if (i_in.frame_start) begin
                // restart: first header byte carries FIN and opcode
                n_fin    = b[7];
                n_opcode = b[3:0];
                n_len_lo = '0;
                n_len_hi = 1'b0;
                n_key    = '0;
                n_cnt    = '0;
                n_idx    = '0;
                n_limit  = i_in.buffer_length[LIM_W-1:0];
                n_phase  = PH_HDR1;
            end else begin
                case (r_phase)
                    PH_HDR1: begin
                        if (!b[7]) begin
                            // unmasked frame: drop the rest of the buffer
                            n_phase = PH_DONE;
                        end else if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
                            n_len_lo = '0;
                            n_len_hi = 1'b0;
                            n_idx    = (len7 == LEN7_EXT64) ? 3'd7 : 3'd1;
                            n_phase  = PH_EXTLEN;
                        end else begin
                            n_len_lo = LIM_W'(len7);
                            n_len_hi = 1'b0;
                            n_idx    = '0;
                            if (LIM_W'(len7) > r_limit) begin
                                n_phase                = PH_DONE;
                                push                   = 1'b1;
                                res.result_kind        = KIND_REJECT;
                                res.last_of_frame      = 1'b1;
                                res.close_request      = 1'b1;
                            end else begin
                                n_phase = PH_KEY;
                            end
                        end
                    end
                    PH_EXTLEN: begin
                        // shift in big-endian length, remember overflow of the low part
                        n_len_lo = len_shift[LIM_W-1:0];
                        n_len_hi = r_len_hi || (|len_shift[LIM_W+7:LIM_W]);
                        if (r_idx == 3'd0) begin
                            n_cnt = '0;
                            if (n_len_hi || (n_len_lo > r_limit)) begin
                                n_phase           = PH_DONE;
                                push              = 1'b1;
                                res.result_kind   = KIND_REJECT;
                                res.last_of_frame = 1'b1;
                                res.close_request = 1'b1;
                            end else begin
                                n_phase = PH_KEY;
                            end
                        end else begin
                            n_idx = r_idx - 3'd1;
                        end
                    end
                    PH_KEY: begin
                        n_key = {r_key[23:0], b};
                        n_idx = r_idx + 3'd1;
                        if (r_idx == 3'd3) begin
                            n_idx = '0;
                            n_cnt = '0;
                            if (r_len_lo == '0) begin
                                // empty frame: one completion result
                                n_phase           = PH_DONE;
                                push              = 1'b1;
                                res.result_kind   = KIND_EMPTY;
                                res.last_of_frame = 1'b1;
                                res.close_request = (r_opcode == OPC_CLOSE);
                            end else begin
                                n_phase = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        n_cnt             = cnt_inc;
                        push              = 1'b1;
                        res.result_kind   = KIND_DATA;
                        res.payload_byte  = b ^ key_byte;
                        res.last_of_frame = last;
                        res.close_request = last && (r_opcode == OPC_CLOSE);
                        if (last) begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: begin
                        // idle or done: ignore stray and trailing bytes
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_idx    <= '0;
            r_opcode <= '0;
            r_fin    <= 1'b0;
            r_len_lo <= '0;
            r_len_hi <= 1'b0;
            r_key    <= '0;
            r_cnt    <= '0;
            r_limit  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_opcode <= n_opcode;
            r_fin    <= n_fin;
            r_len_lo <= n_len_lo;
            r_len_hi <= n_len_hi;
            r_key    <= n_key;
            r_cnt    <= n_cnt;
            r_limit  <= n_limit;
        end
    end

    // Result register and skid entry
    wsrx_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (res),
        .o_ready     (skid_ready),
        .o_valid     (out_valid),
        .o_data      (out_data),
        .i_pop_ready (o_out.ready)
    );

    assign i_in.ready           = skid_ready;
    assign o_out.valid          = out_valid;
    assign o_out.result_kind    = out_data.result_kind;
    assign o_out.payload_byte   = out_data.payload_byte;
    assign o_out.last_of_frame  = out_data.last_of_frame;
    assign o_out.close_request  = out_data.close_request;
    assign o_out.frame_opcode   = out_data.frame_opcode;
    assign o_out.final_fragment = out_data.final_fragment;

endmodule
